// ===== rtl/core/bgce_pkg.sv =====
package bgce_pkg;

    // default sizing of the line stores and the tile size range
    localparam int DEF_MAX_WIDTH     = 1024;
    localparam int DEF_MAX_HEIGHT    = 1024;
    localparam int DEF_MAX_TILE_SIZE = 256;

    // register and field widths
    localparam int GRID_DIM_W  = 11;
    localparam int TILE_SIZE_W = 9;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int POS_W       = 18;
    localparam int KIND_W      = 2;
    localparam int NUM_CORNERS = 4;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TILE_SIZE   = 2'd2;

    // register reset values
    localparam logic [GRID_DIM_W-1:0]  RST_GRID_WIDTH  = 11'd64;
    localparam logic [GRID_DIM_W-1:0]  RST_GRID_HEIGHT = 11'd64;
    localparam logic [TILE_SIZE_W-1:0] RST_TILE_SIZE   = 9'd16;

    // corner kinds, in emission order
    localparam logic [KIND_W-1:0] KIND_TOP_LEFT     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TOP_RIGHT    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BOTTOM_RIGHT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BOTTOM_LEFT  = 2'd3;

    // one judged tile handed to the corner emitter
    typedef struct packed {
        logic [NUM_CORNERS-1:0] show;
        logic [POS_W-1:0]       x_right;
        logic [POS_W-1:0]       y_bottom;
        logic [POS_W-1:0]       step;
    } tile_t;

endpackage

// ===== rtl/core/bgce_if.sv =====
interface bgce_in_if;
    import bgce_pkg::*;

    logic valid;
    logic ready;
    logic solid;

    modport source (output valid, output solid, input ready);
    modport sink (input valid, input solid, output ready);
endinterface

interface bgce_out_if;
    import bgce_pkg::*;

    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  corner_x;
    logic [POS_W-1:0]  corner_y;
    logic [KIND_W-1:0] corner_kind;
    logic              last;

    modport source (output valid, output corner_x, output corner_y, output corner_kind,
                    output last, input ready);
    modport sink (input valid, input corner_x, input corner_y, input corner_kind,
                  input last, output ready);
endinterface

// ===== rtl/core/bgce_corner_emitter.sv =====
module bgce_corner_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tile_valid,
    output logic              tile_ready,
    input  bgce_pkg::tile_t   tile,
    bgce_out_if.source        corner_out
);
    import bgce_pkg::*;

    logic [NUM_CORNERS-1:0] mask_reg;
    logic [NUM_CORNERS-1:0] mask_next;
    logic [POS_W-1:0]       x_right_reg;
    logic [POS_W-1:0]       y_bottom_reg;
    logic [POS_W-1:0]       step_reg;

    logic                   out_valid_reg;
    logic [POS_W-1:0]       out_x_reg;
    logic [POS_W-1:0]       out_y_reg;
    logic [KIND_W-1:0]      out_kind_reg;
    logic                   out_last_reg;

    logic                   load;
    logic [KIND_W-1:0]      sel_kind;
    logic [NUM_CORNERS-1:0] mask_after;
    logic                   sel_last;
    logic [POS_W-1:0]       x_left;
    logic [POS_W-1:0]       y_top;
    logic [POS_W-1:0]       sel_x;
    logic [POS_W-1:0]       sel_y;

    // pick the lowest pending corner
    always_comb
    begin
        sel_kind = KIND_TOP_LEFT;
        if (mask_reg[KIND_TOP_LEFT])
        begin
            sel_kind = KIND_TOP_LEFT;
        end
        else if (mask_reg[KIND_TOP_RIGHT])
        begin
            sel_kind = KIND_TOP_RIGHT;
        end
        else if (mask_reg[KIND_BOTTOM_RIGHT])
        begin
            sel_kind = KIND_BOTTOM_RIGHT;
        end
        else
        begin
            sel_kind = KIND_BOTTOM_LEFT;
        end
    end

    assign mask_after = mask_reg & ~(NUM_CORNERS'(1) << sel_kind);
    assign sel_last   = (mask_after == '0);
    assign load       = (mask_reg != '0) && (!out_valid_reg || corner_out.ready);
    assign tile_ready = (mask_reg == '0) || (load && sel_last);

    // left and top edges sit one tile before right and bottom, modulo the field width
    assign x_left = x_right_reg - step_reg;
    assign y_top  = y_bottom_reg - step_reg;

    always_comb
    begin
        sel_x = x_left;
        sel_y = y_top;
        case (sel_kind)
            KIND_TOP_LEFT:
            begin
                sel_x = x_left;
                sel_y = y_top;
            end
            KIND_TOP_RIGHT:
            begin
                sel_x = x_right_reg;
                sel_y = y_top;
            end
            KIND_BOTTOM_RIGHT:
            begin
                sel_x = x_right_reg;
                sel_y = y_bottom_reg;
            end
            default:
            begin
                sel_x = x_left;
                sel_y = y_bottom_reg;
            end
        endcase
    end

    // pending corner mask
    always_comb
    begin
        mask_next = mask_reg;
        if (tile_valid && tile_ready)
        begin
            mask_next = tile.show;
        end
        else if (load)
        begin
            mask_next = mask_after;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (corner_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // tile positions and output payload
    always_ff @(posedge clk)
    begin
        if (tile_valid && tile_ready)
        begin
            x_right_reg  <= tile.x_right;
            y_bottom_reg <= tile.y_bottom;
            step_reg     <= tile.step;
        end
        if (load)
        begin
            out_x_reg    <= sel_x;
            out_y_reg    <= sel_y;
            out_kind_reg <= sel_kind;
            out_last_reg <= sel_last;
        end
    end

    assign corner_out.valid       = out_valid_reg;
    assign corner_out.corner_x    = out_x_reg;
    assign corner_out.corner_y    = out_y_reg;
    assign corner_out.corner_kind = out_kind_reg;
    assign corner_out.last        = out_last_reg;

    // a new tile is taken only once the current one is drained
    a_take_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        tile_ready |-> (mask_reg == '0) || (load && sel_last))
        else $error("tile taken while corners still pending");

    // a corner not flagged last leaves more corners behind
    a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && !sel_last) |=> (mask_reg != '0))
        else $error("corner mask drained without a last flag");

    // pending corners move whenever the output register is empty
    a_no_idle_with_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (mask_reg != '0 && !out_valid_reg) |-> load)
        else $error("emitter idle with pending corners");

endmodule

// ===== rtl/core/binary_grid_corner_extractor_core.sv =====
// Binary grid corner extractor
// item_in carries one tile occupancy bit per transaction, in raster order over a grid of
// grid_width by grid_height tiles. corner_out carries the corners of the solid regions:
// pixel x and y, the corner kind and a last flag on the final corner of a tile.
// Only tiles off the outer ring are judged; a tile's corners come out when the tile to its
// lower right arrives, in the order top-left, top-right, bottom-right, bottom-left.
// Configuration: cfg_we, cfg_index, cfg_wdata; write only while the block is idle.
// Writing grid_width or grid_height restarts the grid at its first tile.
// The first corner of a judged tile passes the input stage, the emitter's corner mask and
// the result register, in that order, after the input transaction that completes its
// neighborhood. Throughput: one input transaction per cycle while tiles yield no corners;
// otherwise corners leave one at a time (up to four per tile) through the single result
// register. A stalled receiver holds the result register; the corner emitter and then the
// input stage fill up and item_in.ready drops.
// Reset clears the counters, window and registers (64 x 64 grid, tile size 16); the line
// stores need no clearing, as no judged tile uses an entry before it is written.
module binary_grid_corner_extractor_core #(
    parameter int MAX_WIDTH     = bgce_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT    = bgce_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_TILE_SIZE = bgce_pkg::DEF_MAX_TILE_SIZE
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bgce_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bgce_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    bgce_in_if.sink                            item_in,
    bgce_out_if.source                         corner_out
);
    import bgce_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int TS_W   = $clog2(MAX_TILE_SIZE + 1);
    localparam int XPRD_W = COL_W + TS_W;
    localparam int YPRD_W = ROW_W + TS_W;

    function automatic int unsigned clamp_val(int unsigned v, int unsigned lo, int unsigned hi);
        int unsigned r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

    logic [GRID_DIM_W-1:0]  grid_width_reg;
    logic [GRID_DIM_W-1:0]  grid_height_reg;
    logic [TILE_SIZE_W-1:0] tile_size_reg;

    logic [COL_W-1:0]       col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [COL_W-1:0]       w_last;
    logic [ROW_W-1:0]       h_last;
    logic [TS_W-1:0]        ts_eff;

    logic                   in_accept;
    logic                   s1_valid_reg;
    logic                   s1_solid_reg;
    logic [COL_W-1:0]       s1_col_reg;
    logic [ROW_W-1:0]       s1_row_reg;
    logic [1:0]             rd_reg;
    logic                   s1_fire;

    logic [1:0]             store_mem [MAX_WIDTH];

    logic [8:0]             window_reg;
    logic [8:0]             window_next;
    logic                   judge;
    logic [XPRD_W-1:0]      x_prod;
    logic [YPRD_W-1:0]      y_prod;

    logic                   tile_ready;
    tile_t                  tile;

    // effective sizes, saturated to the supported range
    assign w_last = COL_W'(clamp_val(32'(grid_width_reg), 3, MAX_WIDTH) - 1);
    assign h_last = ROW_W'(clamp_val(32'(grid_height_reg), 3, MAX_HEIGHT) - 1);
    assign ts_eff = TS_W'(clamp_val(32'(tile_size_reg), 1, MAX_TILE_SIZE));

    // configuration registers and grid position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
            tile_size_reg   <= RST_TILE_SIZE;
            col_reg         <= '0;
            row_reg         <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GRID_WIDTH:
                begin
                    grid_width_reg <= cfg_wdata;
                    col_reg        <= '0;
                    row_reg        <= '0;
                end
                REG_GRID_HEIGHT:
                begin
                    grid_height_reg <= cfg_wdata;
                    col_reg         <= '0;
                    row_reg         <= '0;
                end
                REG_TILE_SIZE:
                begin
                    tile_size_reg <= cfg_wdata[TILE_SIZE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (in_accept)
        begin
            if (col_reg == w_last)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == h_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // input stage
    assign s1_fire       = s1_valid_reg && tile_ready;
    assign item_in.ready = !s1_valid_reg || tile_ready;
    assign in_accept     = item_in.valid && item_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_solid_reg <= item_in.solid;
            s1_col_reg   <= col_reg;
            s1_row_reg   <= row_reg;
        end
    end

    // line stores: bit 1 holds the row two above, bit 0 the row above
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rd_reg <= store_mem[col_reg];
        end
        if (s1_fire)
        begin
            store_mem[s1_col_reg] <= {rd_reg[0], s1_solid_reg};
        end
    end

    // shift the 3x3 window left and insert the new column
    assign window_next = ((window_reg >> 1) & 9'h0DB) | {s1_solid_reg, 2'b00, rd_reg[0], 2'b00,
                                                        rd_reg[1], 2'b00};

    assign judge = (s1_col_reg >= COL_W'(2)) && (s1_row_reg >= ROW_W'(2)) && window_next[4];

    // corner test: shown when both edges are empty, or both solid with an empty diagonal
    function automatic logic corner_shown(logic e1, logic diag, logic e2);
        return (e1 == e2) && !(e1 && diag);
    endfunction

    // pixel positions of the right and bottom edges of the judged tile
    assign x_prod = XPRD_W'(s1_col_reg) * XPRD_W'(ts_eff);
    assign y_prod = YPRD_W'(s1_row_reg) * YPRD_W'(ts_eff);

    always_comb
    begin
        tile.show = '0;
        if (judge)
        begin
            tile.show[KIND_TOP_LEFT]     = corner_shown(window_next[3], window_next[0],
                                                        window_next[1]);
            tile.show[KIND_TOP_RIGHT]    = corner_shown(window_next[1], window_next[2],
                                                        window_next[5]);
            tile.show[KIND_BOTTOM_RIGHT] = corner_shown(window_next[5], window_next[8],
                                                        window_next[7]);
            tile.show[KIND_BOTTOM_LEFT]  = corner_shown(window_next[7], window_next[6],
                                                        window_next[3]);
        end
        tile.x_right  = POS_W'(x_prod);
        tile.y_bottom = POS_W'(y_prod);
        tile.step     = POS_W'(ts_eff);
    end

    bgce_corner_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .tile_valid (s1_valid_reg),
        .tile_ready (tile_ready),
        .tile       (tile),
        .corner_out (corner_out)
    );

    // position counters stay inside the effective grid
    a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg <= w_last) && (row_reg <= h_last))
        else $error("grid position outside the configured grid");

    // the line store is never read where the pending write lands
    a_store_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && in_accept) |-> (col_reg != s1_col_reg))
        else $error("line store read and write at one column");

    // a stalled input stage holds its item until the emitter takes it
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !tile_ready) |=> s1_valid_reg && $stable(s1_col_reg)
                                          && $stable(window_reg))
        else $error("input stage lost a stalled item");

endmodule
